### design/fvt_pkg.sv
// Shared types and constants of the frustum visibility test.
package fvt_pkg;

	// Number of planes tested and number of planes backed by a register
	localparam int PLANE_COUNT = 6;
	localparam int REG_COUNT   = 6;
	localparam int CFG_IDX_W   = 3;

	// Q1.14 coefficients, distance kept wide enough that no sum can overflow
	localparam int FRAC_BITS = 14;
	localparam int DIST_W    = 36;

	typedef enum logic [1:0] {
		REQ_POINT  = 2'd0,
		REQ_SPHERE = 2'd1,
		REQ_CUBE   = 2'd2,
		REQ_BOX    = 2'd3
	} req_kind_t;

	typedef logic signed [15:0]    coord_t;
	typedef logic signed [15:0]    coef_t;
	typedef logic [14:0]           half_t;
	typedef logic [16:0]           mag_t;
	typedef logic [63:0]           plane_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic signed [31:0]    prod_t;
	typedef logic [31:0]           ext_t;
	typedef logic signed [DIST_W-1:0] dist_t;

	// One primitive after cube half sizes are spread to all three axes
	typedef struct packed {
		req_kind_t kind;
		coord_t    cx;
		coord_t    cy;
		coord_t    cz;
		half_t     hx;
		half_t     hy;
		half_t     hz;
	} prim_t;

endpackage

### design/fvt_req_if.sv
// Request channel: one primitive per transaction.
interface fvt_req_if;
	import fvt_pkg::*;

	logic   valid;
	logic   ready;
	logic [1:0] req_type;
	coord_t center_x;
	coord_t center_y;
	coord_t center_z;
	half_t  half_x;
	half_t  half_y;
	half_t  half_z;

	modport source (
		output valid, req_type, center_x, center_y, center_z, half_x, half_y, half_z,
		input  ready
	);
	modport sink (
		input  valid, req_type, center_x, center_y, center_z, half_x, half_y, half_z,
		output ready
	);
endinterface

### design/fvt_res_if.sv
// Result channel: one visibility bit per transaction.
interface fvt_res_if;
	logic valid;
	logic ready;
	logic visible;

	modport source (output valid, visible, input ready);
	modport sink (input valid, visible, output ready);
endinterface

### design/fvt_cfg_if.sv
// Configuration write channel: register index and 64-bit plane word.
interface fvt_cfg_if;
	import fvt_pkg::*;

	logic     valid;
	logic     ready;
	cfg_idx_t index;
	plane_t   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### design/fvt_plane_regs.sv
// Plane register file written through the configuration channel.
module fvt_plane_regs (
	input  logic            clk,
	input  logic            arst_n,
	fvt_cfg_if.sink         cfg,
	output fvt_pkg::plane_t planes [fvt_pkg::PLANE_COUNT]
);
	import fvt_pkg::*;

	plane_t regs_q [REG_COUNT];

	// Writes are always taken
	assign cfg.ready = 1'b1;

	// Store a plane word; drop writes past the last register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				regs_q[i] <= '0;
			end
		end else if (cfg.valid && (cfg.index < CFG_IDX_W'(REG_COUNT))) begin
			regs_q[cfg.index] <= cfg.data;
		end
	end

	// Planes without a register stay all zero and never reject
	for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_plane
		if (g < REG_COUNT) begin : g_reg
			assign planes[g] = regs_q[g];
		end else begin : g_zero
			assign planes[g] = '0;
		end
	end
endmodule

### design/fvt_lane.sv
// One plane lane: products registered in stage 1, distance test after them.
module fvt_lane (
	input  logic            clk,
	input  logic            load_s1,
	input  fvt_pkg::prim_t  prim,
	input  fvt_pkg::plane_t plane,
	output logic            reject
);
	import fvt_pkg::*;

	coef_t a, b, c, d;
	mag_t  a_mag, b_mag, c_mag;
	prod_t px, py, pz;
	ext_t  ex, ey, ez;

	prod_t     px_s1, py_s1, pz_s1;
	ext_t      ex_s1, ey_s1, ez_s1;
	req_kind_t kind_s1;
	half_t     radius_s1;

	dist_t ctr_dist, slack, total;

	// Unpack plane coefficients
	assign a = plane[15:0];
	assign b = plane[31:16];
	assign c = plane[47:32];
	assign d = plane[63:48];

	// Take magnitudes in 17 bits so the most negative code stays exact
	assign a_mag = a[15] ? mag_t'(-{a[15], a}) : {1'b0, a};
	assign b_mag = b[15] ? mag_t'(-{b[15], b}) : {1'b0, b};
	assign c_mag = c[15] ? mag_t'(-{c[15], c}) : {1'b0, c};

	// Centre products and box extents
	assign px = prod_t'(a) * prod_t'(prim.cx);
	assign py = prod_t'(b) * prod_t'(prim.cy);
	assign pz = prod_t'(c) * prod_t'(prim.cz);
	assign ex = ext_t'(a_mag) * ext_t'(prim.hx);
	assign ey = ext_t'(b_mag) * ext_t'(prim.hy);
	assign ez = ext_t'(c_mag) * ext_t'(prim.hz);

	// Hold products for the distance stage
	always_ff @(posedge clk) begin
		if (load_s1) begin
			px_s1     <= px;
			py_s1     <= py;
			pz_s1     <= pz;
			ex_s1     <= ex;
			ey_s1     <= ey;
			ez_s1     <= ez;
			kind_s1   <= prim.kind;
			radius_s1 <= prim.hx;
		end
	end

	// Centre distance in Q.14
	assign ctr_dist = dist_t'(px_s1) + dist_t'(py_s1) + dist_t'(pz_s1)
		+ (dist_t'(d) <<< FRAC_BITS);

	// Allowance behind the plane by primitive kind
	always_comb begin
		case (kind_s1) inside
			REQ_POINT:         slack = '0;
			REQ_SPHERE:        slack = dist_t'(radius_s1) <<< FRAC_BITS;
			REQ_CUBE, REQ_BOX: slack = dist_t'(ex_s1) + dist_t'(ey_s1) + dist_t'(ez_s1);
			default:           slack = '0;
		endcase
	end

	assign total  = ctr_dist + slack;
	assign reject = total[DIST_W-1];
endmodule

### design/frustum_visibility_test.sv
// Top level of the six-plane frustum visibility test.
//
// Channels: req carries one primitive per transaction (point, sphere, cube or
// box with centre and half sizes), res returns one visible bit per request in
// request order, cfg writes the 64-bit plane words by index (near, far, left,
// right, top, bottom). Writes past the last plane are dropped; cfg is always
// ready and must only be used while no request is in flight.
// Pipeline: an accepted request loads stage 1 with the plane products, and the
// output register then takes the combined verdict that res shows.
// Throughput: one request per cycle while res takes results; every plane has
// its own multiplier lane, so all planes are tested in the same pass.
// Reset: clears all planes to zero (nothing is rejected) and empties the
// pipeline. When res stalls, the result waits in the output register and one
// further request still enters stage 1; req.ready drops only when both are
// full.
module frustum_visibility_test (
	input  logic    clk,
	input  logic    arst_n,
	fvt_req_if.sink req,
	fvt_res_if.source res,
	fvt_cfg_if.sink cfg
);
	import fvt_pkg::*;

	plane_t planes [PLANE_COUNT];
	prim_t  prim;
	logic   [PLANE_COUNT-1:0] reject;
	logic   valid_s1;
	logic   out_valid_q;
	logic   visible_q;
	logic   out_adv;
	logic   load_s1;

	fvt_plane_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.planes (planes)
	);

	// Spread the cube half size to all axes
	always_comb begin
		prim.kind = req_kind_t'(req.req_type);
		prim.cx   = req.center_x;
		prim.cy   = req.center_y;
		prim.cz   = req.center_z;
		prim.hx   = req.half_x;
		prim.hy   = (prim.kind == REQ_CUBE) ? req.half_x : req.half_y;
		prim.hz   = (prim.kind == REQ_CUBE) ? req.half_x : req.half_z;
	end

	for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_lane
		fvt_lane u_lane (
			.clk     (clk),
			.load_s1 (load_s1),
			.prim    (prim),
			.plane   (planes[g]),
			.reject  (reject[g])
		);
	end

	// Handshake: advance each stage when the one after it has room
	assign out_adv   = !out_valid_q || res.ready;
	assign req.ready = !valid_s1 || out_adv;
	assign load_s1   = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (out_adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// Combine the plane verdicts into the output register
	always_ff @(posedge clk) begin
		if (out_adv) begin
			visible_q <= ~|reject;
		end
	end

	assign res.valid   = out_valid_q;
	assign res.visible = visible_q;

	// An empty stage 1 always takes a transaction
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> req.ready)
		else $error("request refused with stage 1 empty");

	// Both stages full and output stalled must block the input
	a_block_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !res.ready) |-> !req.ready)
		else $error("request accepted while pipeline is full");

	// A result only appears behind an occupied stage 1
	a_result_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result produced without a request in stage 1");

	// A taken result is refilled only from stage 1
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res.ready && !valid_s1) |=> !out_valid_q)
		else $error("result repeated after transaction");
endmodule

### bench/fvt_visibility_checker.sv
// Checker for the frustum visibility test: mirrors the plane words and checks every verdict.
module fvt_visibility_checker (
	input  logic clk,
	input  logic arst_n,
	fvt_req_if   req,
	fvt_res_if   res,
	fvt_cfg_if   cfg,
	output int   mismatches,
	output int   outstanding,
	output int   checked,
	output int   visible_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import fvt_pkg::*;

	localparam int     MAX_PLANES = 8;
	localparam longint UNIT       = longint'(1) << FRAC_BITS;

	// Planes without a register stay zero and never cull
	plane_t plane_words [MAX_PLANES];
	logic   pending_verdicts [$];
	int     err_count;
	int     seen_count;
	int     vis_count;

	// Work out whether a primitive survives every plane
	function automatic logic predict_visibility(input req_kind_t kind, input coord_t cx,
			input coord_t cy, input coord_t cz, input half_t h0, input half_t h1,
			input half_t h2);
		longint x, y, z, hx, hy, hz;
		longint a, b, c, d, ctr_dist, reach;
		plane_t p;
		logic   vis;
		x  = cx;
		y  = cy;
		z  = cz;
		hx = h0;
		hy = h1;
		hz = h2;
		// Spread the cube half size over all three axes
		if (kind == REQ_CUBE) begin
			hy = hx;
			hz = hx;
		end
		vis = 1'b1;
		for (int i = 0; i < PLANE_COUNT; i++) begin
			p        = plane_words[i];
			a        = $signed(p[15:0]);
			b        = $signed(p[31:16]);
			c        = $signed(p[47:32]);
			d        = $signed(p[63:48]);
			ctr_dist = a * x + b * y + c * z + d * UNIT;
			reach    = (a < 0 ? -a : a) * hx + (b < 0 ? -b : b) * hy + (c < 0 ? -c : c) * hz;
			case (kind)
				REQ_POINT: begin
					if (ctr_dist < 0)
						vis = 1'b0;
				end
				REQ_SPHERE: begin
					if (ctr_dist < -(hx * UNIT))
						vis = 1'b0;
				end
				default: begin
					if (ctr_dist + reach < 0)
						vis = 1'b0;
				end
			endcase
		end
		return vis;
	endfunction

	// Track plane writes, queue predictions, compare verdicts in order
	always @(posedge clk or negedge arst_n) begin
		logic want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_PLANES; i++)
				plane_words[i] = '0;
			pending_verdicts.delete();
			err_count    = 0;
			seen_count   = 0;
			vis_count    = 0;
			mismatches   <= 0;
			outstanding  <= 0;
			checked      <= 0;
			visible_seen <= 0;
		end else begin
			// Drop writes past the last plane register
			if (cfg.valid && cfg.ready && cfg.index < REG_COUNT)
				plane_words[cfg.index] = cfg.data;
			if (req.valid && req.ready)
				pending_verdicts = {pending_verdicts,
					predict_visibility(req_kind_t'(req.req_type),
					req.center_x, req.center_y, req.center_z,
					req.half_x, req.half_y, req.half_z)};
			if (res.valid && res.ready) begin
				if (pending_verdicts.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("[%0t] unexpected verdict visible=%0b with nothing pending",
							$realtime, res.visible);
				end else begin
					want = pending_verdicts.pop_front();
					seen_count++;
					if (res.visible === 1'b1)
						vis_count++;
					if (res.visible !== want) begin
						err_count++;
						if (err_count <= 10)
							$display("[%0t] verdict %0d: expected visible=%0b, got %0b",
								$realtime, seen_count, want, res.visible);
					end
				end
			end
			mismatches   <= err_count;
			outstanding  <= pending_verdicts.size();
			checked      <= seen_count;
			visible_seen <= vis_count;
		end
	end

endmodule

### bench/frustum_visibility_test_tb.sv
// Testbench top for the frustum visibility test: clock, reset, stimulus and verdict.
module frustum_visibility_test_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fvt_pkg::*;

	// Plane register indexes, plus two codes past the last register
	localparam cfg_idx_t IDX_NEAR      = 3'd0;
	localparam cfg_idx_t IDX_FAR       = 3'd1;
	localparam cfg_idx_t IDX_LEFT      = 3'd2;
	localparam cfg_idx_t IDX_RIGHT     = 3'd3;
	localparam cfg_idx_t IDX_TOP       = 3'd4;
	localparam cfg_idx_t IDX_BOTTOM    = 3'd5;
	localparam cfg_idx_t IDX_PAST_LAST = 3'd6;
	localparam cfg_idx_t IDX_TOP_CODE  = 3'd7;

	localparam int     ONE             = 16384;
	localparam int     ITEMS_PER_PHASE = 205;
	localparam plane_t WORD_MIN_ALL    = 64'h8000_8000_8000_8000;
	localparam plane_t WORD_MAX_ALL    = 64'h7FFF_7FFF_7FFF_7FFF;
	localparam plane_t WORD_ONES       = 64'hFFFF_FFFF_FFFF_FFFF;

	logic clk;
	logic arst_n;
	int   send_idle;
	int   recv_idle;
	int   requests_sent;
	int   settings_loaded;
	int   mismatches;
	int   outstanding;
	int   checked;
	int   visible_seen;

	fvt_req_if req_ch ();
	fvt_res_if res_ch ();
	fvt_cfg_if cfg_ch ();

	frustum_visibility_test dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	fvt_visibility_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_ch),
		.res          (res_ch),
		.cfg          (cfg_ch),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.checked      (checked),
		.visible_seen (visible_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Stall the result side at random
	always @(posedge clk) begin
		res_ch.ready <= arst_n && ($urandom_range(99) >= recv_idle);
	end

	// Give up on a hung run
	initial begin
		#3_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic plane_t plane_word(input int a, input int b, input int c, input int d);
		return {d[15:0], c[15:0], b[15:0], a[15:0]};
	endfunction

	// Drive one request and hold it until accepted
	task automatic send_req(input req_kind_t kind, input int x, input int y, input int z,
			input int hx, input int hy, input int hz);
		while ($urandom_range(99) < send_idle) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.center_x <= x[15:0];
		req_ch.center_y <= y[15:0];
		req_ch.center_z <= z[15:0];
		req_ch.half_x   <= hx[14:0];
		req_ch.half_y   <= hy[14:0];
		req_ch.half_z   <= hz[14:0];
		do @(posedge clk); while (!req_ch.ready);
		requests_sent++;
	endtask

	// Mostly primitives near the frustum, some anywhere in range
	task automatic send_random();
		req_kind_t kind;
		int        x, y, z, hx, hy, hz;
		kind = req_kind_t'($urandom_range(3));
		if ($urandom_range(9) < 7) begin
			x = int'($urandom_range(3200)) - 1600;
			y = int'($urandom_range(3200)) - 1600;
			z = int'($urandom_range(3200)) - 1600;
		end else begin
			x = $urandom();
			y = $urandom();
			z = $urandom();
		end
		if ($urandom_range(9) < 6) begin
			hx = $urandom_range(400);
			hy = $urandom_range(400);
			hz = $urandom_range(400);
		end else begin
			hx = $urandom();
			hy = $urandom();
			hz = $urandom();
		end
		send_req(kind, x, y, z, hx, hy, hz);
	endtask

	// Hold one plane write until accepted; the caller drops valid after the batch
	task automatic write_plane(input cfg_idx_t idx, input plane_t word);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= word;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	// Drop valid and wait until every verdict is back
	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (3) @(posedge clk);
	endtask

	function automatic int tilt();
		return int'($urandom_range(4000)) - 2000;
	endfunction

	// Load all six planes: a tilted box, some raw words, or extreme words
	task automatic load_frustum(input int style);
		plane_t words [6];
		words[IDX_NEAR]   = plane_word(tilt(), tilt(), ONE, $urandom_range(1500));
		words[IDX_FAR]    = plane_word(tilt(), tilt(), -ONE, 200 + $urandom_range(1500));
		words[IDX_LEFT]   = plane_word(ONE, tilt(), tilt(), 200 + $urandom_range(1500));
		words[IDX_RIGHT]  = plane_word(-ONE, tilt(), tilt(), 200 + $urandom_range(1500));
		words[IDX_TOP]    = plane_word(tilt(), -ONE, tilt(), 200 + $urandom_range(1500));
		words[IDX_BOTTOM] = plane_word(tilt(), ONE, tilt(), 200 + $urandom_range(1500));
		if (style == 1) begin
			for (int i = 0; i < 6; i++)
				if ($urandom_range(2) == 0)
					words[i] = {$urandom(), $urandom()};
		end else if (style == 2) begin
			words[IDX_NEAR]  = WORD_MAX_ALL;
			words[IDX_FAR]   = 64'h7FFF_8000_8000_8000;
			words[IDX_LEFT]  = '0;
			words[IDX_RIGHT] = 64'h0000_0000_8000_7FFF;
			words[IDX_TOP]   = 64'h8000_0000_0000_7FFF;
		end
		for (int i = 0; i < 6; i++)
			write_plane(cfg_idx_t'(i), words[i]);
		cfg_ch.valid <= 1'b0;
		settings_loaded++;
	endtask

	initial begin
		arst_n          <= 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.req_type <= REQ_POINT;
		req_ch.center_x <= '0;
		req_ch.center_y <= '0;
		req_ch.center_z <= '0;
		req_ch.half_x   <= '0;
		req_ch.half_y   <= '0;
		req_ch.half_z   <= '0;
		cfg_ch.valid    <= 1'b0;
		cfg_ch.index    <= IDX_NEAR;
		cfg_ch.data     <= '0;
		send_idle       = 25;
		recv_idle       = 50;
		requests_sent   = 0;
		settings_loaded = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Planes cleared by reset reject nothing
		send_req(REQ_POINT, -32768, 32767, -32768, 0, 0, 0);
		send_req(REQ_BOX, 32767, -32768, 32767, 32767, 32767, 32767);
		drain();

		// Load an axis-aligned box frustum, then try writes past the last plane
		write_plane(IDX_NEAR, plane_word(0, 0, ONE, 10));
		write_plane(IDX_FAR, plane_word(0, 0, -ONE, 1000));
		write_plane(IDX_LEFT, plane_word(ONE, 0, 0, 500));
		write_plane(IDX_RIGHT, plane_word(-ONE, 0, 0, 500));
		write_plane(IDX_TOP, plane_word(0, -ONE, 0, 500));
		write_plane(IDX_BOTTOM, plane_word(0, ONE, 0, 500));
		write_plane(IDX_PAST_LAST, 64'h8000_0000_0000_0000);
		write_plane(IDX_TOP_CODE, 64'h8000_0000_0000_0000);
		cfg_ch.valid <= 1'b0;
		settings_loaded++;

		// Points inside, on and just past the planes
		send_req(REQ_POINT, 0, 0, 0, 32767, 32767, 32767);
		send_req(REQ_POINT, 500, 0, 0, 0, 0, 0);
		send_req(REQ_POINT, 501, 0, 0, 0, 0, 0);
		send_req(REQ_POINT, -501, 0, 0, 0, 0, 0);
		send_req(REQ_POINT, 0, 0, -11, 0, 0, 0);
		// Sphere touching the plane versus one unit short
		send_req(REQ_SPHERE, 600, 0, 0, 100, 32767, 32767);
		send_req(REQ_SPHERE, 600, 0, 0, 99, 0, 0);
		// Cube ignores the y and z half sizes
		send_req(REQ_CUBE, 600, 0, 0, 100, 0, 0);
		send_req(REQ_CUBE, 600, 0, 0, 99, 32767, 32767);
		// Box reach depends on the matching axis only
		send_req(REQ_BOX, 600, 0, 0, 100, 0, 0);
		send_req(REQ_BOX, 0, 700, 0, 32767, 199, 0);
		send_req(REQ_BOX, 0, 700, 0, 0, 200, 0);
		// Extreme coordinates and sizes
		send_req(REQ_SPHERE, -32768, -32768, -32768, 32767, 0, 0);
		send_req(REQ_BOX, 32767, -32768, 32767, 32767, 32767, 32767);
		send_req(REQ_CUBE, 32767, 32767, -32768, 0, 32767, 32767);
		drain();

		// Extreme plane words: minimum, maximum, all ones, all zero
		write_plane(IDX_NEAR, WORD_MIN_ALL);
		write_plane(IDX_FAR, WORD_MAX_ALL);
		write_plane(IDX_LEFT, WORD_ONES);
		write_plane(IDX_RIGHT, '0);
		write_plane(IDX_TOP, '0);
		write_plane(IDX_BOTTOM, '0);
		cfg_ch.valid <= 1'b0;
		settings_loaded++;
		send_req(REQ_POINT, -32768, -32768, -32768, 0, 0, 0);
		send_req(REQ_BOX, 32767, 32767, 32767, 32767, 32767, 32767);
		send_req(REQ_SPHERE, -20000, 0, 0, 32767, 0, 0);
		send_req(REQ_CUBE, -32768, -32768, 0, 32767, 0, 0);
		send_req(REQ_BOX, -32768, -32768, -32768, 0, 0, 0);
		drain();

		// Random part: two plane settings under each idling profile
		for (int ph = 0; ph < 6; ph++) begin
			case (ph / 2)
				0: begin
					send_idle = 25;
					recv_idle = 50;
				end
				1: begin
					send_idle = 50;
					recv_idle = 25;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			load_frustum(ph % 3);
			repeat (ITEMS_PER_PHASE) send_random();
			drain();
		end
		repeat (8) @(posedge clk);

		$display("Run covered %0d requests of all four kinds over %0d plane settings.",
			requests_sent, settings_loaded);
		$display("Verdicts checked: %0d (%0d visible, %0d culled), mismatches: %0d.",
			checked, visible_seen, checked - visible_seen, mismatches);
		if (mismatches == 0 && outstanding == 0 && checked == requests_sent) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

### frustum_visibility_test.f
design/fvt_pkg.sv
design/fvt_req_if.sv
design/fvt_res_if.sv
design/fvt_cfg_if.sv
design/fvt_plane_regs.sv
design/fvt_lane.sv
design/frustum_visibility_test.sv
bench/fvt_visibility_checker.sv
bench/frustum_visibility_test_tb.sv
